/* rtl/core/convex_polygon_overlap_test_top_defines.svh */
// Assertion macros for the overlap test block
`ifndef CONVEX_POLYGON_OVERLAP_TEST_TOP_DEFINES_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CPO_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define CPO_ASSERT_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error("%m failed");
`else
`define CPO_ASSERT_IMPL(label, clk, rst, prop)
`define CPO_ASSERT_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

/* rtl/core/cpo_pkg.sv */
package cpo_pkg;
   localparam int MaxVertices = 8;
   localparam int CoordBits   = 16;
   localparam int IdxBits     = $clog2(MaxVertices);
   localparam int CntBits     = $clog2(MaxVertices + 1);
   // edge normal 17b, coord 16b: product 33b, dot 34b
   localparam int DiffBits    = CoordBits + 1;
   localparam int DotBits     = 2 * CoordBits + 2;

   localparam logic [1:0] ModeVertA  = 2'd0;
   localparam logic [1:0] ModeVertB  = 2'd1;
   localparam logic [1:0] ModeCircA  = 2'd2;
   localparam logic [1:0] ModeCircB  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        radius;
      logic               last;
   } req_type;

   typedef struct packed {
      logic colliding;
      logic bad_shape;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EDGE0, ST_EDGE1, ST_PROJ, ST_CMP, ST_CIRC, ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic               load;      // capture item, write vertex
      logic               edge_rd0;  // read edge start vertex
      logic               edge_rd1;  // read edge end vertex, latch start vertex
      logic               proj;      // project one vertex of each polygon
      logic               axis_cmp;  // form edge normal from end vertex
      logic               clr;       // clear counts after a test
      logic               set_sep;   // latch separation
      logic               sel_b;     // axes come from polygon B
      logic [IdxBits-1:0] eidx;      // edge index
      logic [IdxBits-1:0] vidx;      // projection vertex index
      logic               vfirst;    // first projection on this axis
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [CntBits-1:0] count_a;
      logic [CntBits-1:0] count_b;
      logic               overflow;
      logic               separated;
      logic [1:0]         mode;
      logic               last;
   } sts_type;
endpackage

/* rtl/core/cpo_ram.sv */
module cpo_ram #(
   parameter int Width = 16,
   parameter int Depth = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/cpo_datapath.sv */
module cpo_datapath import cpo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    circ_hit
);
   logic [CntBits-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic               ovf_ff, ovf_in, sep_ff, sep_in;
   logic signed [15:0] cax_ff, cay_ff;
   logic [14:0]        car_ff;
   req_type            item_ff;

   logic wr_a, wr_b;
   logic [IdxBits-1:0] rd_a, rd_b;
   logic signed [15:0] ax, ay, bx, by;

   assign wr_a = cmd.load && req.mode == ModeVertA && count_a_ff < CntBits'(MaxVertices);
   assign wr_b = cmd.load && req.mode == ModeVertB && count_b_ff < CntBits'(MaxVertices);

   // edge reads use the polygon of the axis, projection reads both
   always_comb begin
      rd_a = cmd.vidx;
      rd_b = cmd.vidx;
      if (cmd.edge_rd0 || cmd.edge_rd1) begin
         rd_a = cmd.eidx;
         rd_b = cmd.eidx;
      end
   end

   cpo_ram #(.Width(16), .Depth(MaxVertices)) u_ax (.clock, .wr_en(wr_a),
      .wr_addr(count_a_ff[IdxBits-1:0]), .wr_data(req.x), .rd_addr(rd_a), .rd_data(ax));
   cpo_ram #(.Width(16), .Depth(MaxVertices)) u_ay (.clock, .wr_en(wr_a),
      .wr_addr(count_a_ff[IdxBits-1:0]), .wr_data(req.y), .rd_addr(rd_a), .rd_data(ay));
   cpo_ram #(.Width(16), .Depth(MaxVertices)) u_bx (.clock, .wr_en(wr_b),
      .wr_addr(count_b_ff[IdxBits-1:0]), .wr_data(req.x), .rd_addr(rd_b), .rd_data(bx));
   cpo_ram #(.Width(16), .Depth(MaxVertices)) u_by (.clock, .wr_en(wr_b),
      .wr_addr(count_b_ff[IdxBits-1:0]), .wr_data(req.y), .rd_addr(rd_b), .rd_data(by));

   // edge start vertex, then normal
   logic signed [15:0]         e0x_ff, e0y_ff, ex, ey;
   logic signed [DiffBits-1:0] nx_ff, ny_ff;
   assign ex = cmd.sel_b ? bx : ax;
   assign ey = cmd.sel_b ? by : ay;

   // projection products, registered, then sums and min/max
   logic signed [DotBits-2:0] pax_ff, pay_ff, pbx_ff, pby_ff;
   logic                      pvld_ff, pfirst_ff, pvld2_ff, pfirst2_ff;
   logic signed [DotBits-1:0] da, db;
   logic signed [DotBits-1:0] alo_ff, ahi_ff, blo_ff, bhi_ff;
   logic                      pa_en_ff, pb_en_ff, pa_en2_ff, pb_en2_ff;

   assign da = DotBits'(pax_ff) + DotBits'(pay_ff);
   assign db = DotBits'(pbx_ff) + DotBits'(pby_ff);

   // circle test, combinational from the captured item and circle A
   logic signed [16:0] cdx, cdy;
   logic [15:0]        crs;
   logic [33:0]        cd2;
   logic [31:0]        cr2;
   assign cdx = 17'(item_ff.x) - 17'(cax_ff);
   assign cdy = 17'(item_ff.y) - 17'(cay_ff);
   assign crs = 16'(item_ff.radius) + 16'(car_ff);
   assign cd2 = 34'(cdx * cdx) + 34'(cdy * cdy);
   assign cr2 = crs * crs;
   assign circ_hit = cd2 <= 34'(cr2);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      ovf_in     = ovf_ff;
      sep_in     = sep_ff;
      if (wr_a) count_a_in = count_a_ff + 1'b1;
      if (wr_b) count_b_in = count_b_ff + 1'b1;
      if (cmd.load && ((req.mode == ModeVertA && !wr_a) || (req.mode == ModeVertB && !wr_b)))
         ovf_in = 1'b1;
      if (cmd.load) sep_in = 1'b0;
      if (cmd.set_sep && (ahi_ff < blo_ff || bhi_ff < alo_ff)) sep_in = 1'b1;
      if (cmd.clr) begin
         count_a_in = '0;
         count_b_in = '0;
         ovf_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         ovf_ff     <= 1'b0;
         sep_ff     <= 1'b0;
         cax_ff     <= '0;
         cay_ff     <= '0;
         car_ff     <= '0;
         pvld_ff    <= 1'b0;
         pvld2_ff   <= 1'b0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         ovf_ff     <= ovf_in;
         sep_ff     <= sep_in;
         pvld_ff    <= cmd.proj;
         pvld2_ff   <= pvld_ff;
         if (cmd.load && req.mode == ModeCircA) begin
            cax_ff <= req.x;
            cay_ff <= req.y;
            car_ff <= req.radius;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req;
      if (cmd.edge_rd1) begin
         e0x_ff <= ex;
         e0y_ff <= ey;
      end
      if (cmd.axis_cmp) begin
         // normal = (-(ey0-ey1), ex0-ex1)
         nx_ff <= DiffBits'(ey) - DiffBits'(e0y_ff);
         ny_ff <= DiffBits'(e0x_ff) - DiffBits'(ex);
      end
      // flags follow the RAM read stage and the product stage
      pfirst_ff  <= cmd.vfirst;
      pa_en_ff   <= {1'b0, cmd.vidx} < count_a_ff;
      pb_en_ff   <= {1'b0, cmd.vidx} < count_b_ff;
      pfirst2_ff <= pfirst_ff;
      pa_en2_ff  <= pa_en_ff;
      pb_en2_ff  <= pb_en_ff;
      pax_ff <= nx_ff * ax;
      pay_ff <= ny_ff * ay;
      pbx_ff <= nx_ff * bx;
      pby_ff <= ny_ff * by;
      if (pvld2_ff && pa_en2_ff) begin
         if (pfirst2_ff || da < alo_ff) alo_ff <= da;
         if (pfirst2_ff || da > ahi_ff) ahi_ff <= da;
      end
      if (pvld2_ff && pb_en2_ff) begin
         if (pfirst2_ff || db < blo_ff) blo_ff <= db;
         if (pfirst2_ff || db > bhi_ff) bhi_ff <= db;
      end
   end

   assign sts.count_a   = count_a_ff;
   assign sts.count_b   = count_b_ff;
   assign sts.overflow  = ovf_ff;
   assign sts.separated = sep_ff;
   assign sts.mode      = item_ff.mode;
   assign sts.last      = item_ff.last;
endmodule

/* rtl/core/cpo_ctrl.sv */
module cpo_ctrl import cpo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  sts_type sts,
   input  logic    circ_hit,
   output cmd_type cmd,
   output state_type state
);
   // Axis loop: per edge, two vertex reads, then one projection per vertex
   // (first index k=0 of the stream starts on the same axis), then a drain of
   // the RAM read and product stages before the interval compare.
   state_type state_ff, state_in;
   logic [IdxBits-1:0] eidx_ff, eidx_in;
   logic [CntBits-1:0] vcnt_ff, vcnt_in;
   logic               selb_ff, selb_in;
   logic [1:0]         drain_ff, drain_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;
   logic [CntBits-1:0] ncnt, vmax;
   logic [IdxBits-1:0] enext;
   logic               wrap;

   assign ncnt  = selb_ff ? sts.count_b : sts.count_a;
   assign vmax  = (sts.count_a > sts.count_b) ? sts.count_a : sts.count_b;
   assign wrap  = CntBits'(eidx_ff) + 1'b1 >= ncnt;
   assign enext = wrap ? '0 : eidx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      eidx_in  = eidx_ff;
      vcnt_in  = vcnt_ff;
      selb_in  = selb_ff;
      drain_in = drain_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && !rsp_ready;
      cmd      = '0;
      cmd.sel_b = selb_ff;
      cmd.eidx  = eidx_ff;
      cmd.vidx  = vcnt_ff[IdxBits-1:0];
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rspv_ff;
            if (req_valid && !rspv_ff) begin
               cmd.load = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // decide what the captured transaction needs
            state_in = ST_IDLE;
            if (sts.mode == ModeCircB) begin
               state_in = ST_CIRC;
            end else if (sts.mode == ModeVertB && sts.last) begin
               if (sts.overflow || sts.count_a == '0 || sts.count_b == '0) begin
                  rsp_in.colliding = 1'b0;
                  rsp_in.bad_shape = sts.overflow;
                  rspv_in  = 1'b1;
                  cmd.clr  = 1'b1;
               end else begin
                  eidx_in  = '0;
                  selb_in  = 1'b0;
                  state_in = ST_EDGE0;
               end
            end
         end
         ST_CIRC: begin
            rsp_in.colliding = circ_hit;
            rsp_in.bad_shape = 1'b0;
            rspv_in  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EDGE0: begin
            // read edge start vertex
            cmd.edge_rd0 = 1'b1;
            state_in = ST_EDGE1;
         end
         ST_EDGE1: begin
            // start data ready; read end vertex
            cmd.edge_rd1 = 1'b1;
            cmd.eidx     = enext;
            state_in     = ST_CMP;
            drain_in     = 2'd0;
         end
         ST_CMP: begin
            if (drain_ff == 2'd0) begin
               // end vertex data ready: build normal
               cmd.axis_cmp = 1'b1;
               vcnt_in  = '0;
               state_in = ST_PROJ;
            end else if (drain_ff == 2'd3) begin
               cmd.set_sep = 1'b1;
               drain_in = 2'd2;
            end else begin
               // separation latched; next axis or finish
               if (sts.separated || (wrap && selb_ff)) begin
                  rsp_in.colliding = !sts.separated;
                  rsp_in.bad_shape = 1'b0;
                  rspv_in  = 1'b1;
                  cmd.clr  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  if (wrap) begin
                     selb_in = 1'b1;
                     eidx_in = '0;
                  end else begin
                     eidx_in = enext;
                  end
                  state_in = ST_EDGE0;
               end
            end
         end
         ST_PROJ: begin
            // one read per cycle, then drain RAM and product stages
            if (vcnt_ff < vmax) begin
               cmd.proj   = 1'b1;
               cmd.vfirst = vcnt_ff == '0;
               vcnt_in    = vcnt_ff + 1'b1;
               drain_in   = 2'd0;
            end else begin
               drain_in = drain_ff + 1'b1;
               if (drain_ff == 2'd2) begin
                  drain_in = 2'd3;
                  state_in = ST_CMP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rspv_ff  <= 1'b0;
         eidx_ff  <= '0;
         vcnt_ff  <= '0;
         selb_ff  <= 1'b0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         eidx_ff  <= eidx_in;
         vcnt_ff  <= vcnt_in;
         selb_ff  <= selb_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
   assign state     = state_ff;
endmodule

/* rtl/core/convex_polygon_overlap_test_top.sv */
// Polygon test: each edge of A, then of B, gives an axis on which vmax vertex
// indices are projected, vmax being the larger vertex count; the test stops
// at the first separating axis.
// Throughput: one transaction at a time; next accepted once result is taken.
// Reset: synchronous, active high; clears counts, flags, circle A, control.
`include "convex_polygon_overlap_test_top_defines.svh"
module convex_polygon_overlap_test_top import cpo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   cmd_type   cmd;
   sts_type   sts;
   logic      circ_hit;
   state_type state;

   cpo_datapath u_dp (.clock, .reset, .req(req_data), .cmd, .sts, .circ_hit);
   cpo_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_data, .sts, .circ_hit, .cmd, .state);

   `CPO_ASSERT_IMPL(a_bad_not_coll, clock, reset, rsp_valid |-> !(rsp_data.colliding && rsp_data.bad_shape))
   `CPO_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready |-> (state == ST_IDLE && !rsp_valid))
   `CPO_ASSERT_NEXT(a_load_done, clock, reset, req_valid && req_ready, state == ST_DONE)
endmodule

/* tb/sv/convex_polygon_overlap_test_top_test.sv */
module convex_polygon_overlap_test_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cpo_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   convex_polygon_overlap_test_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // shadow state of the collision engine
   longint ax[MaxVertices], ay[MaxVertices], bx[MaxVertices], by[MaxVertices];
   int      cnt_a, cnt_b;
   bit      ovf;
   longint  cax, cay, car;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      n_rsp = 0, n_hit = 0, n_bad = 0;
   bit      stim_done = 1'b0;
   bit      long_hold = 1'b0;
   logic    req_ready_q = 1'b0;

   // true if some edge of the given polygon separates the two shapes
   function automatic bit edge_separates(bit from_b);
      int     n, j;
      longint nx, ny, d, alo, ahi, blo, bhi;
      n = from_b ? cnt_b : cnt_a;
      for (int i = 0; i < n; i++) begin
         j  = (i + 1 < n) ? i + 1 : 0;
         nx = from_b ? -(by[i] - by[j]) : -(ay[i] - ay[j]);
         ny = from_b ? (bx[i] - bx[j]) : (ax[i] - ax[j]);
         for (int k = 0; k < cnt_a; k++) begin
            d = nx * ax[k] + ny * ay[k];
            if (k == 0 || d < alo) alo = d;
            if (k == 0 || d > ahi) ahi = d;
         end
         for (int k = 0; k < cnt_b; k++) begin
            d = nx * bx[k] + ny * by[k];
            if (k == 0 || d < blo) blo = d;
            if (k == 0 || d > bhi) bhi = d;
         end
         if (ahi < blo || bhi < alo) return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the shadow state by one transaction, queue any result
   task automatic predict_overlap(input req_type t);
      rsp_type r;
      longint  x, y, dx, dy, rs;
      x = longint'(t.x);
      y = longint'(t.y);
      r = '0;
      case (t.mode)
         ModeVertA: begin
            if (cnt_a >= MaxVertices) ovf = 1'b1;
            else begin
               ax[cnt_a] = x; ay[cnt_a] = y; cnt_a++;
            end
         end
         ModeCircA: begin
            cax = x; cay = y; car = longint'(t.radius);
         end
         ModeCircB: begin
            dx = x - cax; dy = y - cay; rs = longint'(t.radius) + car;
            r.colliding = (dx * dx + dy * dy <= rs * rs);
            expected_rsps.push_back(r);
         end
         default: begin
            if (cnt_b >= MaxVertices) ovf = 1'b1;
            else begin
               bx[cnt_b] = x; by[cnt_b] = y; cnt_b++;
            end
            if (t.last) begin
               if (ovf) r.bad_shape = 1'b1;
               else if (cnt_a != 0 && cnt_b != 0)
                  r.colliding = !(edge_separates(1'b0) || edge_separates(1'b1));
               expected_rsps.push_back(r);
               cnt_a = 0; cnt_b = 0; ovf = 1'b0;
            end
         end
      endcase
   endtask

   function automatic req_type mk(logic [1:0] m, int x, int y, int rad, bit lst);
      req_type t;
      t.mode = m; t.x = x[15:0]; t.y = y[15:0]; t.radius = rad[14:0]; t.last = lst;
      return t;
   endfunction

   // random polygon: mostly small coordinates so that overlaps are common
   task automatic add_polygon(logic [1:0] m, int n, int cx, int cy, int span);
      for (int i = 0; i < n; i++)
         pending_reqs.push_back(mk(m, cx + $urandom_range(0, 2 * span) - span,
                                   cy + $urandom_range(0, 2 * span) - span,
                                   $urandom, (m == ModeVertB) && (i == n - 1)));
   endtask

   // stimulus
   initial begin
      int na, nb, span;
      // directed: circles, triangles touching, extremes, overflow, empty
      pending_reqs.push_back(mk(ModeCircB, 3, 4, 5, 0));           // circle A still zero
      pending_reqs.push_back(mk(ModeCircA, -32768, -32768, 32767, 0));
      pending_reqs.push_back(mk(ModeCircB, 32767, 32767, 32767, 1));
      pending_reqs.push_back(mk(ModeCircB, 32767, 32767, 0, 0));
      add_polygon(ModeVertA, 0, 0, 0, 0);
      pending_reqs.push_back(mk(ModeVertA, 0, 0, 0, 0));
      pending_reqs.push_back(mk(ModeVertA, 10, 0, 0, 1));
      pending_reqs.push_back(mk(ModeVertA, 10, 10, 0, 0));
      pending_reqs.push_back(mk(ModeVertB, 10, 0, 0, 0));          // touching at a vertex
      pending_reqs.push_back(mk(ModeVertB, 20, 0, 0, 0));
      pending_reqs.push_back(mk(ModeVertB, 20, 10, 0, 1));
      pending_reqs.push_back(mk(ModeVertA, -32768, -32768, 0, 0)); // extremes
      pending_reqs.push_back(mk(ModeVertA, 32767, -32768, 0, 0));
      pending_reqs.push_back(mk(ModeVertA, 32767, 32767, 0, 0));
      pending_reqs.push_back(mk(ModeVertB, -32768, 32767, 32767, 1));
      pending_reqs.push_back(mk(ModeVertB, 5, 5, 0, 1));           // empty polygon A
      for (int i = 0; i < 10; i++)                                 // store full on A
         pending_reqs.push_back(mk(ModeVertA, i, -i, 0, 0));
      pending_reqs.push_back(mk(ModeVertB, 1, 1, 0, 1));
      for (int i = 0; i < 9; i++)                                  // store full on B
         pending_reqs.push_back(mk(ModeVertB, i, i, 0, i == 8));
      pending_reqs.push_back(mk(ModeVertB, 7, 7, 0, 1));           // one-point B, A empty
      // random part: mostly well-formed shape pairs
      while (pending_reqs.size() < 620) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               span = $urandom_range(0, 1) ? 32767 : 200;
               pending_reqs.push_back(mk(ModeCircA, $urandom, $urandom, $urandom, $urandom));
               pending_reqs.push_back(mk(ModeCircB, $urandom_range(0, 1) ?
                  $urandom : $urandom_range(0, 400), $urandom, $urandom_range(0, 1) ?
                  $urandom : $urandom_range(0, span), $urandom));
            end
            2: pending_reqs.push_back(mk($urandom, $urandom, $urandom, $urandom,
                                         $urandom));
            default: begin
               na = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 5);
               nb = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 5);
               span = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(1, 60);
               add_polygon(ModeVertA, na, 0, 0, span);
               add_polygon(ModeVertB, nb, $urandom_range(0, 80) - 40,
                           $urandom_range(0, 80) - 40, span);
            end
         endcase
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: one transaction per handshake, random gaps
   always @(negedge clock) begin
      static int gap = 0;
      static req_type cur;
      if (!reset && !stim_done) begin
         if (req_valid && req_ready_q) begin
            req_valid <= 1'b0;
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
         end else if (!req_valid) begin
            if (gap > 0) gap--;
            else if (pending_reqs.size() != 0) begin
               cur = pending_reqs.pop_front();
               req_data  <= cur;
               req_valid <= 1'b1;
            end else stim_done <= 1'b1;
         end
      end
   end

   // accept sampled at the rising edge, seen by the driver on the next falling edge
   always @(posedge clock) begin
      req_ready_q <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) predict_overlap(req_data);
   end

   // receiver: random stalls, one long hold-off early in the run
   always @(negedge clock) begin
      static int stall = 0;
      static int hold_cnt = 0;
      if (!reset) begin
         if (!long_hold && n_rsp == 3) begin
            long_hold = 1'b1;
            hold_cnt = 300;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_ready && rsp_valid)
               stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %b", $realtime, rsp_data);
         end else begin
            exp_r = expected_rsps.pop_front();
            if (rsp_data.colliding !== exp_r.colliding) begin
               errors++;
               $display("%0t: colliding expected %b actual %b", $realtime,
                        exp_r.colliding, rsp_data.colliding);
            end
            if (rsp_data.bad_shape !== exp_r.bad_shape) begin
               errors++;
               $display("%0t: bad_shape expected %b actual %b", $realtime,
                        exp_r.bad_shape, rsp_data.bad_shape);
            end
            n_hit += exp_r.colliding;
            n_bad += exp_r.bad_shape;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $realtime, expected_rsps.size());
      end
      $display("Checked %0d results: %0d collisions, %0d oversized polygons.",
               n_rsp, n_hit, n_bad);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cpo_pkg.sv
rtl/core/cpo_ram.sv
rtl/core/cpo_datapath.sv
rtl/core/cpo_ctrl.sv
rtl/core/convex_polygon_overlap_test_top.sv
tb/sv/convex_polygon_overlap_test_top_test.sv
